### design/cdoc_pkg.sv
// package: shared constants for the column dark offset corrector
package cdoc_pkg;

   // column store and field geometry
   localparam int MAX_WIDTH     = 4096;
   localparam int FRAC_BITS     = 4;
   localparam int COL_BITS      = 12;
   localparam int ROW_BITS      = 12;
   localparam int PIX_BITS      = 16;
   localparam int OUT_BITS      = 21;
   localparam int CFG_BITS      = 13;
   localparam int CSR_INDEX_BITS = 1;

   localparam int MEM_COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ADDR_BITS     = MEM_COL_BITS + 1;
   localparam int MEM_DEPTH     = 2 * MAX_WIDTH;
   localparam int HCOL_BITS     = MEM_COL_BITS - 1;
   localparam int HALF_BITS     = CFG_BITS - 1;

   // sum and difference arithmetic
   localparam int SUM_BITS      = 28;
   localparam int NUM_BITS      = SUM_BITS + 3;
   localparam int MAG_BITS      = SUM_BITS + 1;

   // profile divider
   localparam int Q_BITS        = OUT_BITS;
   localparam int DVD_BITS      = MAG_BITS + FRAC_BITS;
   localparam int HI_BITS       = DVD_BITS - Q_BITS;
   localparam int DIV_BITS      = CFG_BITS + 1;
   localparam int DIV_STEPS     = 3;
   localparam int DIV_STAGES    = (Q_BITS + DIV_STEPS - 1) / DIV_STEPS;

   // output arithmetic
   localparam int RES_BITS      = OUT_BITS + 2;
   localparam logic signed [RES_BITS-1:0] OUT_MIN_RES = RES_BITS'(-(2 ** (OUT_BITS - 1)));
   localparam logic signed [RES_BITS-1:0] OUT_MAX_RES = RES_BITS'((2 ** (OUT_BITS - 1)) - 1);

   localparam int MIN_WIDTH     = 4;
   localparam int RESTART_ROWS  = 2;
   localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(4096);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

   // commands
   localparam logic CMD_ACCUMULATE = 1'b0;
   localparam logic CMD_CORRECT    = 1'b1;

endpackage

### design/column_dark_offset_correction.sv
// top level: column dark offset correction over a twice-streamed bayer frame
// The block takes one pixel transaction per clock in both passes as long as the output
// buffer has room, and stalls when the result side holds it; a correct transaction's
// result passes through a pipeline: one stage forms column store addresses, one reads
// three copies of the column store (own column and both same-colour neighbours, each copy
// read once per cycle and written with every sum), one forms the sum difference and
// writes back the accumulated sum, one loads the divider, seven divider stages resolve
// three quotient bits each, and a final register holds the saturated result. Accumulate
// transactions travel the same pipe and produce nothing. A read-after-write to the column
// store from back-to-back pixels is served by a one-deep bypass. Sums are 28-bit and
// wrap; the store has no clearing pass, so a frame must accumulate rows 0 and 1 (which
// restart every column sum) before its correct pass. A two-entry output buffer lets the
// pipe keep moving for one more result when the result side stalls.
module column_dark_offset_correction (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write port
   input  logic                               csr_wr_en,
   input  logic [cdoc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cdoc_pkg::CFG_BITS-1:0]       csr_wr_data,
   // pixel transactions
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [cdoc_pkg::COL_BITS-1:0]       req_column,
   input  logic [cdoc_pkg::ROW_BITS-1:0]       req_row,
   input  logic signed [cdoc_pkg::PIX_BITS-1:0] req_pixel,
   // result transactions
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [cdoc_pkg::OUT_BITS-1:0] rsp_corrected_pixel
);
   import cdoc_pkg::*;

   // address stage contents, also carried through the read stage
   typedef struct packed {
      logic                       valid;
      logic                       cmd;
      logic                       restart;
      logic                       store_ok;
      logic                       zero;
      logic signed [PIX_BITS-1:0] pix;
      logic [ADDR_BITS-1:0]       addr_cur;
      logic [ADDR_BITS-1:0]       addr_left;
      logic [ADDR_BITS-1:0]       addr_right;
   } front_type;

   // sum difference stage
   typedef struct packed {
      logic                       valid;
      logic                       cmd;
      logic                       zero;
      logic signed [PIX_BITS-1:0] pix;
      logic signed [NUM_BITS-1:0] num;
   } diff_type;

   // divider stage: partial remainder, unconsumed dividend bits, quotient so far
   typedef struct packed {
      logic                       valid;
      logic                       cmd;
      logic                       sat;
      logic signed [PIX_BITS-1:0] pix;
      logic [DIV_BITS-1:0]        rem;
      logic [Q_BITS-1:0]          dvd;
      logic [Q_BITS-1:0]          quo;
   } div_type;

   logic                  adv;

   // configuration
   logic [CFG_BITS-1:0]   frame_width_ff, frame_width_in;
   logic [CFG_BITS-1:0]   frame_height_ff, frame_height_in;
   logic [CFG_BITS-1:0]   width_lim;
   logic [CFG_BITS-1:0]   width_eff;
   logic [HALF_BITS-1:0]  half;
   logic [HALF_BITS-1:0]  half_m1;
   logic [HALF_BITS-1:0]  half_m2;
   logic [DIV_BITS-1:0]   divisor;

   // address stage
   logic [HCOL_BITS-1:0]  hcol;
   logic [HCOL_BITS-1:0]  hleft;
   logic [HCOL_BITS-1:0]  hright;
   front_type             s1_ff, s1_in;
   front_type             s2_ff, s2_in;

   // column store, three copies written alike
   logic [SUM_BITS-1:0]   mem_cur   [MEM_DEPTH];
   logic [SUM_BITS-1:0]   mem_left  [MEM_DEPTH];
   logic [SUM_BITS-1:0]   mem_right [MEM_DEPTH];
   logic [SUM_BITS-1:0]   rd_cur_ff, rd_left_ff, rd_right_ff;
   logic                  byp_cur_ff, byp_left_ff, byp_right_ff;
   logic                  byp_cur_in, byp_left_in, byp_right_in;
   logic [SUM_BITS-1:0]   byp_sum_ff;
   logic                  mem_wr;
   logic [SUM_BITS-1:0]   sum_cur, sum_left, sum_right, sum_new;
   logic signed [NUM_BITS-1:0] ext_cur, ext_left, ext_right;

   diff_type              s3_ff, s3_in;

   // divider
   logic                  pos;
   logic [DVD_BITS-1:0]   dvd_full;
   logic [HI_BITS-1:0]    dvd_hi;
   div_type               div_ff [DIV_STAGES+1];
   div_type               div_in [DIV_STAGES+1];

   // output
   logic signed [RES_BITS-1:0] pix_scaled;
   logic signed [RES_BITS-1:0] res_full;
   logic [OUT_BITS-1:0]   res_sat;
   logic                  fin_valid;
   logic                  out_valid_ff, out_valid_in;
   logic [OUT_BITS-1:0]   out_data_ff, out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [OUT_BITS-1:0]   skid_data_ff, skid_data_in;

   // whole pipe moves together while the output buffer has room
   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   // ---------------------------------------------------------------- configuration
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               frame_width_in = csr_wr_data;
            end
            REG_FRAME_HEIGHT: begin
               frame_height_in = csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_RESET;
         frame_height_ff <= CFG_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // width limited to the store and made even; height zero acts as one
   assign width_lim = (frame_width_ff > CFG_BITS'(MAX_WIDTH)) ? CFG_BITS'(MAX_WIDTH)
                                                               : frame_width_ff;
   assign width_eff = {width_lim[CFG_BITS-1:1], 1'b0};
   assign half      = width_lim[CFG_BITS-1:1];
   assign half_m1   = half - HALF_BITS'(1);
   assign half_m2   = half - HALF_BITS'(2);
   assign divisor   = {((frame_height_ff == '0) ? CFG_BITS'(1) : frame_height_ff), 1'b0};

   // ---------------------------------------------------------------- address stage
   // same-colour neighbours sit two columns away, mirrored at both edges
   assign hcol   = req_column[MEM_COL_BITS-1:1];
   assign hleft  = (hcol == '0) ? HCOL_BITS'(1) : hcol - HCOL_BITS'(1);
   assign hright = (HALF_BITS'(hcol) == half_m1) ? half_m2[HCOL_BITS-1:0]
                                                 : hcol + HCOL_BITS'(1);

   always_comb begin
      s1_in.valid      = req_valid;
      s1_in.cmd        = req_command;
      s1_in.restart    = req_row < ROW_BITS'(RESTART_ROWS);
      s1_in.store_ok   = CFG_BITS'(req_column) < CFG_BITS'(MAX_WIDTH);
      s1_in.zero       = (width_eff < CFG_BITS'(MIN_WIDTH)) ||
                         (CFG_BITS'(req_column) >= width_eff);
      s1_in.pix        = req_pixel;
      s1_in.addr_cur   = {req_row[0], req_column[MEM_COL_BITS-1:0]};
      s1_in.addr_left  = {req_row[0], hleft, req_column[0]};
      s1_in.addr_right = {req_row[0], hright, req_column[0]};
   end

   assign s2_in = s1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   // ---------------------------------------------------------------- column store
   assign mem_wr = adv && s2_ff.valid && (s2_ff.cmd == CMD_ACCUMULATE) && s2_ff.store_ok;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem_cur[s2_ff.addr_cur] <= sum_new;
      end
      if (adv) begin
         rd_cur_ff <= mem_cur[s1_ff.addr_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem_left[s2_ff.addr_cur] <= sum_new;
      end
      if (adv) begin
         rd_left_ff <= mem_left[s1_ff.addr_left];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem_right[s2_ff.addr_cur] <= sum_new;
      end
      if (adv) begin
         rd_right_ff <= mem_right[s1_ff.addr_right];
      end
   end

   // write in the same cycle as the read: take the new sum instead
   assign byp_cur_in   = mem_wr && (s1_ff.addr_cur   == s2_ff.addr_cur);
   assign byp_left_in  = mem_wr && (s1_ff.addr_left  == s2_ff.addr_cur);
   assign byp_right_in = mem_wr && (s1_ff.addr_right == s2_ff.addr_cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_cur_ff   <= 1'b0;
         byp_left_ff  <= 1'b0;
         byp_right_ff <= 1'b0;
      end else if (adv) begin
         byp_cur_ff   <= byp_cur_in;
         byp_left_ff  <= byp_left_in;
         byp_right_ff <= byp_right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         byp_sum_ff <= sum_new;
      end
   end

   // ---------------------------------------------------------------- read stage
   assign sum_cur   = byp_cur_ff   ? byp_sum_ff : rd_cur_ff;
   assign sum_left  = byp_left_ff  ? byp_sum_ff : rd_left_ff;
   assign sum_right = byp_right_ff ? byp_sum_ff : rd_right_ff;

   // rows 0 and 1 restart the column sum
   assign sum_new = (s2_ff.restart ? '0 : sum_cur) +
                    {{(SUM_BITS-PIX_BITS){s2_ff.pix[PIX_BITS-1]}}, s2_ff.pix};

   assign ext_cur   = {{(NUM_BITS-SUM_BITS){sum_cur[SUM_BITS-1]}},   sum_cur};
   assign ext_left  = {{(NUM_BITS-SUM_BITS){sum_left[SUM_BITS-1]}},  sum_left};
   assign ext_right = {{(NUM_BITS-SUM_BITS){sum_right[SUM_BITS-1]}}, sum_right};

   always_comb begin
      s3_in.valid = s2_ff.valid;
      s3_in.cmd   = s2_ff.cmd;
      s3_in.zero  = s2_ff.zero;
      s3_in.pix   = s2_ff.pix;
      s3_in.num   = (ext_cur <<< 1) - ext_left - ext_right;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (adv) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------------------------------------------------------- divider
   // correction = floor(max(0, 2s-l-r) * 2^frac / (2*height)), saturated at 2^q
   assign pos      = !s3_ff.zero && !s3_ff.num[NUM_BITS-1] && (s3_ff.num != '0);
   assign dvd_full = pos ? (DVD_BITS'(s3_ff.num[MAG_BITS-1:0]) << FRAC_BITS) : '0;
   assign dvd_hi   = dvd_full[DVD_BITS-1:Q_BITS];

   always_comb begin
      div_type          st;
      logic [DIV_BITS:0] trial;
      div_in[0].valid = s3_ff.valid;
      div_in[0].cmd   = s3_ff.cmd;
      div_in[0].pix   = s3_ff.pix;
      div_in[0].sat   = DIV_BITS'(dvd_hi) >= divisor;
      div_in[0].rem   = DIV_BITS'(dvd_hi);
      div_in[0].dvd   = dvd_full[Q_BITS-1:0];
      div_in[0].quo   = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         st = div_ff[k-1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            if ((k - 1) * DIV_STEPS + j < Q_BITS) begin
               trial  = {st.rem, st.dvd[Q_BITS-1]};
               st.dvd = st.dvd << 1;
               if (trial >= {1'b0, divisor}) begin
                  trial  = trial - {1'b0, divisor};
                  st.quo = {st.quo[Q_BITS-2:0], 1'b1};
               end else begin
                  st.quo = {st.quo[Q_BITS-2:0], 1'b0};
               end
               st.rem = trial[DIV_BITS-1:0];
            end
         end
         div_in[k] = st;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
         if (reset) begin
            div_ff[k].valid <= 1'b0;
         end else if (adv) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // ---------------------------------------------------------------- output
   assign pix_scaled = {{(RES_BITS-PIX_BITS){div_ff[DIV_STAGES].pix[PIX_BITS-1]}},
                        div_ff[DIV_STAGES].pix} <<< FRAC_BITS;
   assign res_full   = pix_scaled -
                       $signed({{(RES_BITS-Q_BITS){1'b0}}, div_ff[DIV_STAGES].quo});

   always_comb begin
      if (div_ff[DIV_STAGES].sat || (res_full < OUT_MIN_RES)) begin
         res_sat = OUT_MIN_RES[OUT_BITS-1:0];
      end else if (res_full > OUT_MAX_RES) begin
         res_sat = OUT_MAX_RES[OUT_BITS-1:0];
      end else begin
         res_sat = res_full[OUT_BITS-1:0];
      end
   end

   // only correct transactions leave a result
   assign fin_valid = div_ff[DIV_STAGES].valid && (div_ff[DIV_STAGES].cmd == CMD_CORRECT);

   // output register backed by one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = adv && fin_valid;
            out_data_in  = res_sat;
         end
      end else if (adv && fin_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_corrected_pixel = out_data_ff;

   // ---------------------------------------------------------------- assertions
   // skid entry is only ever behind a held output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // skid fills only when a result arrives against a stalled output
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready))
      else $error("skid entry filled while output was free");

   // a pixel outside the corrected width enters the divider with zero dividend
   a_zero_corr: assert property (@(posedge clock) disable iff (reset)
      (adv && s3_ff.valid && s3_ff.zero) |=> ((div_ff[0].rem == '0) && !div_ff[0].sat))
      else $error("zero correction pixel loaded nonzero dividend");

   // bypass only follows a column store write
   a_bypass_src: assert property (@(posedge clock) disable iff (reset)
      $rose(byp_cur_ff) |-> $past(s2_ff.valid && (s2_ff.cmd == CMD_ACCUMULATE)))
      else $error("bypass taken without an accumulate write");

endmodule
